// ===== sv/nfc_pkg.sv =====
// Shared types and constants for the NOR flash command block.
// Used by the front classifier, the job queue and the back engine.
`timescale 1ns / 1ps
`default_nettype none
package nfc_pkg;

	// Actions the back engine carries out for one transaction.
	localparam logic [1:0] ACT_NONE    = 2'd0;
	localparam logic [1:0] ACT_READ    = 2'd1;
	localparam logic [1:0] ACT_PROGRAM = 2'd2;
	localparam logic [1:0] ACT_ERASE   = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] CFG_GEOMETRY  = 2'd0;
	localparam logic [1:0] CFG_SIZE      = 2'd1;
	localparam logic [1:0] CFG_WE_USE    = 2'd2;
	localparam logic [1:0] CFG_ADDR_REV  = 2'd3;

	// Command sequence states.
	localparam logic [2:0] ST_IDLE          = 3'd0;
	localparam logic [2:0] ST_UNLOCK        = 3'd1;
	localparam logic [2:0] ST_COMMAND       = 3'd2;
	localparam logic [2:0] ST_PROGRAM       = 3'd3;
	localparam logic [2:0] ST_ERASE_UNLOCK1 = 3'd4;
	localparam logic [2:0] ST_ERASE_UNLOCK2 = 3'd5;
	localparam logic [2:0] ST_ERASE_COMMAND = 3'd6;

	// Sector geometries.
	localparam logic [1:0] GEO_UNIFORM   = 2'd0;
	localparam logic [1:0] GEO_TOP_2MBIT = 2'd1;
	localparam logic [1:0] GEO_TOP_4MBIT = 2'd2;

	localparam logic [11:0] CA_FIRST      = 12'h555;
	localparam logic [11:0] CA_SECOND     = 12'h2aa;
	localparam logic [11:0] CA_FIRST_REV  = 12'haaa;
	localparam logic [11:0] CA_SECOND_REV = 12'h554;

	localparam logic [7:0] CODE_UNLOCK1 = 8'haa;
	localparam logic [7:0] CODE_UNLOCK2 = 8'h55;
	localparam logic [7:0] CODE_PROGRAM = 8'ha0;
	localparam logic [7:0] CODE_ERASE   = 8'h80;
	localparam logic [7:0] CODE_CHIP    = 8'h10;
	localparam logic [7:0] CODE_SECTOR  = 8'h30;
	localparam logic [7:0] ERASED_BYTE  = 8'hff;

	// One classified transaction handed from the front to the back.
	typedef struct packed {
		logic [1:0]  action;
		logic [18:0] addr;
		logic [15:0] data;
		logic [19:0] lo;
		logic [19:0] hi;
		logic [2:0]  state;
		logic        err;
	} job_t;

endpackage
`default_nettype wire

// ===== sv/nfc_front.sv =====
// Front part: configuration registers, command sequence decoding and
// classification of each transaction into a job. Depends on nfc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nfc_front #(
	parameter int ADDRESS_BITS = 19
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_valid,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [19:0]   cfg_data,
	input  wire logic          push,
	input  wire logic          operation,
	input  wire logic [18:0]   address,
	input  wire logic [15:0]   write_data,
	input  wire logic          write_enable,
	output nfc_pkg::job_t      job
);

	localparam logic [19:0] DEPTH = 20'(2 ** ADDRESS_BITS);

	logic [1:0]  geometry_q;
	logic [19:0] size_q;
	logic        we_use_q;
	logic        addr_rev_q;
	logic [2:0]  seq_q;
	logic [2:0]  seq_next;
	logic [19:0] eff_size;
	logic [11:0] ca_first;
	logic [11:0] ca_second;
	logic        at_first;
	logic        at_second;
	logic [16:0] sec_size;
	logic [19:0] addr_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geometry_q <= nfc_pkg::GEO_TOP_4MBIT;
			size_q     <= 20'd524288;
			we_use_q   <= 1'b0;
			addr_rev_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				nfc_pkg::CFG_GEOMETRY: geometry_q <= cfg_data[1:0];
				nfc_pkg::CFG_SIZE:     size_q     <= cfg_data;
				nfc_pkg::CFG_WE_USE:   we_use_q   <= cfg_data[0];
				default:               addr_rev_q <= cfg_data[0];
			endcase
		end
	end

	assign eff_size  = (size_q > DEPTH) ? DEPTH : size_q;
	assign ca_first  = addr_rev_q ? nfc_pkg::CA_FIRST_REV : nfc_pkg::CA_FIRST;
	assign ca_second = addr_rev_q ? nfc_pkg::CA_SECOND_REV : nfc_pkg::CA_SECOND;
	assign at_first  = (address[11:0] == ca_first);
	assign at_second = (address[11:0] == ca_second);
	assign addr_ext  = {1'b0, address};

	// Size of the sector that starts at the address, zero when none does.
	always_comb begin
		sec_size = 17'd0;
		unique case (geometry_q)
			nfc_pkg::GEO_UNIFORM: begin
				if (address <= 19'h1c000 && address[13:0] == 14'd0) sec_size = 17'h4000;
			end
			nfc_pkg::GEO_TOP_2MBIT: begin
				if (address == 19'h00000 || address == 19'h10000 || address == 19'h20000)
					sec_size = 17'h10000;
				else if (address == 19'h30000) sec_size = 17'h8000;
				else if (address == 19'h38000 || address == 19'h3a000) sec_size = 17'h2000;
				else if (address == 19'h3c000) sec_size = 17'h4000;
			end
			nfc_pkg::GEO_TOP_4MBIT: begin
				if (address <= 19'h70000 && address[15:0] == 16'd0) sec_size = 17'h10000;
				else if (address == 19'h78000 || address == 19'h7a000) sec_size = 17'h2000;
				else if (address == 19'h7c000) sec_size = 17'h4000;
			end
			default: sec_size = 17'd0;
		endcase
	end

	always_comb begin
		seq_next   = seq_q;
		job        = '0;
		job.addr   = address;
		job.data   = write_data;
		job.action = nfc_pkg::ACT_NONE;
		if (!operation) begin
			job.action = nfc_pkg::ACT_READ;
		end else if (we_use_q && !write_enable) begin
			seq_next = nfc_pkg::ST_IDLE;
		end else begin
			unique case (seq_q)
				nfc_pkg::ST_IDLE: begin
					if (at_first && write_data[7:0] == nfc_pkg::CODE_UNLOCK1)
						seq_next = nfc_pkg::ST_UNLOCK;
				end
				nfc_pkg::ST_UNLOCK: begin
					seq_next = (at_second && write_data[7:0] == nfc_pkg::CODE_UNLOCK2) ?
						nfc_pkg::ST_COMMAND : nfc_pkg::ST_IDLE;
				end
				nfc_pkg::ST_COMMAND: begin
					if (at_first && write_data[7:0] == nfc_pkg::CODE_PROGRAM)
						seq_next = nfc_pkg::ST_PROGRAM;
					else if (at_first && write_data[7:0] == nfc_pkg::CODE_ERASE)
						seq_next = nfc_pkg::ST_ERASE_UNLOCK1;
					else
						seq_next = nfc_pkg::ST_IDLE;
				end
				nfc_pkg::ST_PROGRAM: begin
					if (addr_ext + 20'd2 <= eff_size) job.action = nfc_pkg::ACT_PROGRAM;
					seq_next = nfc_pkg::ST_IDLE;
				end
				nfc_pkg::ST_ERASE_UNLOCK1: begin
					seq_next = (at_first && write_data[7:0] == nfc_pkg::CODE_UNLOCK1) ?
						nfc_pkg::ST_ERASE_UNLOCK2 : nfc_pkg::ST_IDLE;
				end
				nfc_pkg::ST_ERASE_UNLOCK2: begin
					seq_next = (at_second && write_data[7:0] == nfc_pkg::CODE_UNLOCK2) ?
						nfc_pkg::ST_ERASE_COMMAND : nfc_pkg::ST_IDLE;
				end
				nfc_pkg::ST_ERASE_COMMAND: begin
					if (at_first && write_data[7:0] == nfc_pkg::CODE_CHIP) begin
						job.action = nfc_pkg::ACT_ERASE;
						job.lo     = 20'd0;
						job.hi     = eff_size;
					end else if (write_data[7:0] == nfc_pkg::CODE_SECTOR) begin
						if (sec_size != 17'd0 && addr_ext + {3'b0, sec_size} <= eff_size) begin
							job.action = nfc_pkg::ACT_ERASE;
							job.lo     = addr_ext;
							job.hi     = addr_ext + {3'b0, sec_size};
						end else begin
							job.err = 1'b1;
						end
					end
					seq_next = nfc_pkg::ST_IDLE;
				end
				default: seq_next = nfc_pkg::ST_IDLE;
			endcase
		end
		job.state = seq_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= nfc_pkg::ST_IDLE;
		end else if (push) begin
			seq_q <= seq_next;
		end
	end

endmodule
`default_nettype wire

// ===== sv/nfc_queue.sv =====
// Two-entry job queue between the front and the back engine.
// Depends on nfc_pkg for the job type.
`timescale 1ns / 1ps
`default_nettype none
module nfc_queue (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  nfc_pkg::job_t push_job,
	input  wire logic     pop,
	output nfc_pkg::job_t head,
	output logic          not_empty,
	output logic          full
);

	nfc_pkg::job_t slot_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    count_q;

	assign head      = slot_q[rd_q];
	assign not_empty = (count_q != 2'd0);
	assign full      = (count_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule
`default_nettype wire

// ===== sv/nfc_back.sv =====
// Back engine: byte store, clearing pass, reads, word program and erase
// walks, plus the output register. Depends on nfc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nfc_back #(
	parameter int ADDRESS_BITS = 19
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  nfc_pkg::job_t    head,
	input  wire logic        not_empty,
	output logic             pop,
	output logic             clearing,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      read_data,
	output logic [2:0]       command_state,
	output logic             erase_error
);

	localparam int AB = ADDRESS_BITS;

	localparam logic [2:0] B_CLEAR = 3'd0;
	localparam logic [2:0] B_IDLE  = 3'd1;
	localparam logic [2:0] B_RD0   = 3'd2;
	localparam logic [2:0] B_RD1   = 3'd3;
	localparam logic [2:0] B_RD2   = 3'd4;
	localparam logic [2:0] B_PG1   = 3'd5;
	localparam logic [2:0] B_PG2   = 3'd6;
	localparam logic [2:0] B_ERASE = 3'd7;

	logic [7:0]    mem_q [2 ** AB];
	logic [7:0]    rdata_q;
	logic [7:0]    hi_q;
	logic [2:0]    st_q;
	logic [AB:0]   ptr_q;
	nfc_pkg::job_t job_q;
	logic          emit_q;
	logic [15:0]   res_q;
	logic [AB-1:0] a0;
	logic [AB-1:0] a1;
	logic [AB-1:0] ra;
	logic [AB-1:0] wa;
	logic [7:0]    wd;
	logic          we;
	logic          out_free;

	assign a0       = job_q.addr[AB-1:0];
	assign a1       = a0 + {{(AB-1){1'b0}}, 1'b1};
	assign out_free = !out_valid || !out_stall;
	assign clearing = (st_q == B_CLEAR);
	assign pop      = (st_q == B_IDLE) && !emit_q && not_empty;

	always_comb begin
		ra = a0;
		wa = ptr_q[AB-1:0];
		wd = nfc_pkg::ERASED_BYTE;
		we = 1'b0;
		unique case (st_q)
			B_CLEAR: we = 1'b1;
			B_RD1:   ra = a1;
			B_PG1: begin
				ra = a1;
				wa = a0;
				wd = rdata_q & job_q.data[15:8];
				we = 1'b1;
			end
			B_PG2: begin
				wa = a1;
				wd = rdata_q & job_q.data[7:0];
				we = 1'b1;
			end
			B_ERASE: we = (ptr_q != job_q.hi[AB:0]);
			default: ra = a0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem_q[wa] <= wd;
		rdata_q <= mem_q[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= B_CLEAR;
			ptr_q         <= '0;
			emit_q        <= 1'b0;
			out_valid     <= 1'b0;
			job_q         <= '0;
			res_q         <= 16'd0;
			hi_q          <= 8'd0;
			read_data     <= 16'd0;
			command_state <= nfc_pkg::ST_IDLE;
			erase_error   <= 1'b0;
		end else begin
			// A finished job waits here until the output register is free.
			if (emit_q && out_free) begin
				emit_q        <= 1'b0;
				out_valid     <= 1'b1;
				read_data     <= res_q;
				command_state <= job_q.state;
				erase_error   <= job_q.err;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (st_q)
				B_CLEAR: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q[AB-1:0] == {AB{1'b1}}) st_q <= B_IDLE;
				end
				B_IDLE: begin
					if (pop) begin
						job_q <= head;
						res_q <= 16'd0;
						ptr_q <= head.lo[AB:0];
						unique case (head.action)
							nfc_pkg::ACT_READ:    st_q <= B_RD0;
							nfc_pkg::ACT_PROGRAM: st_q <= B_RD0;
							nfc_pkg::ACT_ERASE:   st_q <= B_ERASE;
							default:              emit_q <= 1'b1;
						endcase
					end
				end
				B_RD0: st_q <= (job_q.action == nfc_pkg::ACT_PROGRAM) ? B_PG1 : B_RD1;
				B_RD1: begin
					hi_q <= rdata_q;
					st_q <= B_RD2;
				end
				B_RD2: begin
					res_q  <= {hi_q, rdata_q};
					emit_q <= 1'b1;
					st_q   <= B_IDLE;
				end
				B_PG1: st_q <= B_PG2;
				B_PG2: begin
					emit_q <= 1'b1;
					st_q   <= B_IDLE;
				end
				B_ERASE: begin
					if (ptr_q == job_q.hi[AB:0]) begin
						emit_q <= 1'b1;
						st_q   <= B_IDLE;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== sv/nor_flash_command_fsm_top.sv =====
// NOR flash command decoder model with unlock sequences, program and erase.
// Top level joining nfc_front, nfc_queue and nfc_back; depends on nfc_pkg.
//
// Usage: bus accesses enter on the input channel (in_valid / in_stall) as
// operation, address, write_data and write_enable. Each transaction gives
// exactly one result on the output channel (out_valid / out_stall):
// read_data, command_state and erase_error. Configuration registers are
// written through cfg_valid / cfg_ready / cfg_index / cfg_data, always
// ready, and should only change while the block is idle.
// After reset the byte store is filled with 0xFF by a clearing pass over
// every address; in_stall stays high until it ends. The front classifies
// one transaction per cycle, while in_stall is low, into a two-entry queue.
// The back engine, limited by the byte store's one read and one write port,
// reads a word as two bytes, programs a word by ANDing each byte in turn,
// erases one byte at a time and passes a plain command write straight on;
// it takes a new job once the last result has moved to the output register.
// When the receiver holds out_stall, the result register keeps its value,
// the back engine waits and the queue fills, after which in_stall rises.
`timescale 1ns / 1ps
`default_nettype none
module nor_flash_command_fsm_top #(
	parameter int ADDRESS_BITS = 19
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [19:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        operation,
	input  wire logic [18:0] address,
	input  wire logic [15:0] write_data,
	input  wire logic        write_enable,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      read_data,
	output logic [2:0]       command_state,
	output logic             erase_error
);

	nfc_pkg::job_t new_job;
	nfc_pkg::job_t head;
	logic          push;
	logic          pop;
	logic          not_empty;
	logic          full;
	logic          clearing;

	assign cfg_ready = 1'b1;
	assign in_stall  = full || clearing;
	assign push      = in_valid && !in_stall;

	nfc_front #(.ADDRESS_BITS(ADDRESS_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.push(push), .operation(operation), .address(address),
		.write_data(write_data), .write_enable(write_enable), .job(new_job)
	);

	nfc_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_job(new_job),
		.pop(pop), .head(head), .not_empty(not_empty), .full(full)
	);

	nfc_back #(.ADDRESS_BITS(ADDRESS_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .not_empty(not_empty),
		.pop(pop), .clearing(clearing), .out_valid(out_valid),
		.out_stall(out_stall), .read_data(read_data),
		.command_state(command_state), .erase_error(erase_error)
	);

endmodule
`default_nettype wire

// ===== tb/nor_flash_command_fsm_top_tb.sv =====
// Self-checking testbench for the NOR flash command decoder top level.
// Depends on nfc_pkg and nor_flash_command_fsm_top; keeps its own flash image.
`timescale 1ns / 1ps
module nor_flash_command_fsm_top_tb;
	import nfc_pkg::*;

	localparam int unsigned DEPTH = 1 << 19;
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef struct packed {
		logic        op;
		logic [18:0] addr;
		logic [15:0] data;
		logic        we;
	} bus_item_t;

	typedef struct packed {
		logic [15:0] rd;
		logic [2:0]  st;
		logic        err;
	} bus_result_t;

	typedef struct {
		bus_item_t   item;
		bit          typed;
		bus_result_t want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [19:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic        operation;
	logic [18:0] address;
	logic [15:0] write_data;
	logic        write_enable;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] read_data;
	logic [2:0]  command_state;
	logic        erase_error;

	nor_flash_command_fsm_top uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .operation(operation),
		.address(address), .write_data(write_data), .write_enable(write_enable),
		.out_valid(out_valid), .out_stall(out_stall), .read_data(read_data),
		.command_state(command_state), .erase_error(erase_error)
	);

	// Flash image and sequence state as the block should hold them.
	logic [7:0]  flash_img [0:DEPTH-1];
	logic [2:0]  seq_state;
	logic [1:0]  geo_cfg;
	logic [19:0] size_cfg;
	logic        we_use_cfg;
	logic        rev_cfg;

	stim_row_t   stim_rows[$];
	bus_result_t pending_results[$];
	int          n_errors;
	int          n_checked;
	int          burst_left;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#80000000;
		$display("status: fail");
		$finish;
	end

	task automatic report(input string field, input int got, input int want);
		$display("mismatch on %s: got %0h, expected %0h", field, got, want);
		n_errors++;
	endtask

	function automatic int unsigned eff_size();
		return (size_cfg > DEPTH) ? DEPTH : size_cfg;
	endfunction

	function automatic logic [11:0] cmd_addr(input bit first);
		if (rev_cfg)
			return first ? CA_FIRST_REV : CA_SECOND_REV;
		return first ? CA_FIRST : CA_SECOND;
	endfunction

	function automatic bit cmd_hit(input bus_item_t it, input bit first, input logic [7:0] code);
		return it.addr[11:0] == cmd_addr(first) && it.data[7:0] == code;
	endfunction

	function automatic int unsigned sector_bytes(input int unsigned a);
		case (geo_cfg)
			GEO_UNIFORM: begin
				if (a <= 'h1c000 && a % 'h4000 == 0) return 'h4000;
			end
			GEO_TOP_2MBIT: begin
				if (a == 'h00000 || a == 'h10000 || a == 'h20000) return 'h10000;
				if (a == 'h30000) return 'h8000;
				if (a == 'h38000 || a == 'h3a000) return 'h2000;
				if (a == 'h3c000) return 'h4000;
			end
			GEO_TOP_4MBIT: begin
				if (a <= 'h70000 && a % 'h10000 == 0) return 'h10000;
				if (a == 'h78000 || a == 'h7a000) return 'h2000;
				if (a == 'h7c000) return 'h4000;
			end
			default: ;
		endcase
		return 0;
	endfunction

	function automatic bus_result_t predict_access(input bus_item_t it);
		bus_result_t r;
		logic [18:0] a1;
		int unsigned a, lim, sz;
		r = '0;
		a = it.addr;
		lim = eff_size();
		if (it.op == OP_READ) begin
			a1 = it.addr + 19'd1;
			r.rd = {flash_img[it.addr], flash_img[a1]};
		end else if (we_use_cfg && !it.we) begin
			seq_state = ST_IDLE;
		end else begin
			case (seq_state)
				ST_IDLE: if (cmd_hit(it, 1, CODE_UNLOCK1)) seq_state = ST_UNLOCK;
				ST_UNLOCK: seq_state = cmd_hit(it, 0, CODE_UNLOCK2) ? ST_COMMAND : ST_IDLE;
				ST_COMMAND: begin
					if (cmd_hit(it, 1, CODE_PROGRAM)) seq_state = ST_PROGRAM;
					else if (cmd_hit(it, 1, CODE_ERASE)) seq_state = ST_ERASE_UNLOCK1;
					else seq_state = ST_IDLE;
				end
				ST_PROGRAM: begin
					if (a < lim && lim - a >= 2) begin
						flash_img[a] = flash_img[a] & it.data[15:8];
						flash_img[a + 1] = flash_img[a + 1] & it.data[7:0];
					end
					seq_state = ST_IDLE;
				end
				ST_ERASE_UNLOCK1:
					seq_state = cmd_hit(it, 1, CODE_UNLOCK1) ? ST_ERASE_UNLOCK2 : ST_IDLE;
				ST_ERASE_UNLOCK2:
					seq_state = cmd_hit(it, 0, CODE_UNLOCK2) ? ST_ERASE_COMMAND : ST_IDLE;
				ST_ERASE_COMMAND: begin
					if (cmd_hit(it, 1, CODE_CHIP)) begin
						for (int unsigned i = 0; i < lim; i++) flash_img[i] = ERASED_BYTE;
					end else if (it.data[7:0] == CODE_SECTOR) begin
						sz = sector_bytes(a);
						if (sz == 0 || a > lim || sz > lim - a) begin
							r.err = 1'b1;
						end else begin
							for (int unsigned i = 0; i < sz; i++) flash_img[a + i] = ERASED_BYTE;
						end
					end
					seq_state = ST_IDLE;
				end
				default: seq_state = ST_IDLE;
			endcase
		end
		r.st = seq_state;
		return r;
	endfunction

	// Called at a rising edge; returns at the edge where the transaction is accepted.
	task automatic send_access(input stim_row_t row);
		bus_result_t r;
		in_valid <= 1'b1;
		operation <= row.item.op;
		address <= row.item.addr;
		write_data <= row.item.data;
		write_enable <= row.item.we;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		r = predict_access(row.item);
		pending_results.push_back(row.typed ? row.want : r);
	endtask

	task automatic run_rows();
		stim_row_t row;
		while (stim_rows.size() != 0) begin
			row = stim_rows.pop_front();
			if (burst_left == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = $urandom_range(1, 40);
			end
			send_access(row);
			burst_left--;
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [19:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_GEOMETRY: geo_cfg = val[1:0];
			CFG_SIZE:     size_cfg = val;
			CFG_WE_USE:   we_use_cfg = val[0];
			default:      rev_cfg = val[0];
		endcase
	endtask

	task automatic add_row(input logic op, input logic [18:0] a, input logic [15:0] d,
			input bit typed, input logic [15:0] rd, input logic [2:0] st, input logic err);
		stim_row_t row;
		row.item = '{op: op, addr: a, data: d, we: 1'b1};
		row.typed = typed;
		row.want = '{rd: rd, st: st, err: err};
		stim_rows.push_back(row);
	endtask

	task automatic add_write(input logic [18:0] a, input logic [15:0] d);
		stim_row_t row;
		row.item = '{op: OP_WRITE, addr: a, data: d, we: 1'b1};
		if (we_use_cfg) row.item.we = ($urandom_range(0, 9) != 0);
		else row.item.we = $urandom_range(0, 1);
		row.typed = 0;
		row.want = '0;
		stim_rows.push_back(row);
	endtask

	function automatic logic [18:0] cmd_at(input bit first);
		logic [6:0] hi;
		hi = $urandom;
		return {hi, cmd_addr(first)};
	endfunction

	function automatic logic [18:0] near_addr();
		if ($urandom_range(0, 9) < 7) return $urandom_range(0, eff_size() + 1);
		return $urandom;
	endfunction

	// Sector start candidates; without chip_ok only starts of sectors of 16 KB or less, or a random address.
	function automatic logic [18:0] sector_pick(input bit chip_ok);
		logic [18:0] small_starts [6] = '{'h78000, 'h7a000, 'h7c000, 'h38000, 'h3a000, 'h3c000};
		int k;
		k = chip_ok ? $urandom_range(0, 3) : 2 + $urandom_range(0, 1);
		case (k)
			0: return {$urandom_range(0, 7), 16'h0};
			1: return $urandom_range(0, 7) * 'h4000;
			2: return small_starts[$urandom_range(0, 5)];
			default: return $urandom;
		endcase
	endfunction

	task automatic gen_phase(input int n, input bit chip_ok);
		int kind, cut, start;
		logic [15:0] d;
		start = stim_rows.size();
		while (stim_rows.size() - start < n) begin
			kind = $urandom_range(0, 99);
			if (kind < 30) begin
				add_write(cmd_at(1), {$urandom_range(0, 255), CODE_UNLOCK1});
				add_write(cmd_at(0), {$urandom_range(0, 255), CODE_UNLOCK2});
				add_write(cmd_at(1), {$urandom_range(0, 255), CODE_PROGRAM});
				add_write(near_addr(), $urandom);
			end else if (kind < 45) begin
				add_write(cmd_at(1), {$urandom_range(0, 255), CODE_UNLOCK1});
				add_write(cmd_at(0), {$urandom_range(0, 255), CODE_UNLOCK2});
				add_write(cmd_at(1), {$urandom_range(0, 255), CODE_ERASE});
				add_write(cmd_at(1), {$urandom_range(0, 255), CODE_UNLOCK1});
				add_write(cmd_at(0), {$urandom_range(0, 255), CODE_UNLOCK2});
				cut = $urandom_range(0, 9);
				if (chip_ok && cut < 3) begin
					add_write(cmd_at(1), {$urandom_range(0, 255), CODE_CHIP});
				end else if (cut < 8) begin
					add_write(sector_pick(chip_ok), {$urandom_range(0, 255), CODE_SECTOR});
				end else begin
					d = $urandom;
					if (d[7:0] == CODE_CHIP || d[7:0] == CODE_SECTOR) d[7:0] = CODE_PROGRAM;
					add_write($urandom, d);
				end
			end else if (kind < 65) begin
				add_row(OP_READ, near_addr(), $urandom, 0, '0, '0, 1'b0);
				stim_rows[stim_rows.size() - 1].item.we = $urandom_range(0, 1);
			end else if (kind < 85) begin
				add_write($urandom, $urandom);
			end else begin
				// Broken sequence: a partial unlock prefix followed by a stray write.
				cut = $urandom_range(1, 4);
				add_write(cmd_at(1), {$urandom_range(0, 255), CODE_UNLOCK1});
				if (cut > 1) add_write(cmd_at(0), {$urandom_range(0, 255), CODE_UNLOCK2});
				if (cut > 2) add_write(cmd_at(1), {$urandom_range(0, 255), CODE_ERASE});
				if (cut > 3) add_write(cmd_at(1), {$urandom_range(0, 255), CODE_UNLOCK1});
				d = $urandom;
				if (d[7:0] == CODE_UNLOCK1 || d[7:0] == CODE_UNLOCK2) d[7:0] = 8'h00;
				add_write($urandom, d);
			end
		end
	endtask

	task automatic run_phase(input logic [1:0] geo, input logic [19:0] sz, input logic we_use,
			input logic rev, input bit chip_ok);
		drain();
		cfg_write(CFG_GEOMETRY, {18'd0, geo});
		cfg_write(CFG_SIZE, sz);
		cfg_write(CFG_WE_USE, {19'd0, we_use});
		cfg_write(CFG_ADDR_REV, {19'd0, rev});
		gen_phase(200, chip_ok);
		run_rows();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		operation = 1'b0;
		address = '0;
		write_data = '0;
		write_enable = 1'b0;
		n_errors = 0;
		burst_left = 0;
		for (int unsigned i = 0; i < DEPTH; i++) flash_img[i] = ERASED_BYTE;
		seq_state = ST_IDLE;
		geo_cfg = GEO_TOP_4MBIT;
		size_cfg = 20'd524288;
		we_use_cfg = 1'b0;
		rev_cfg = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset configuration.
		add_row(OP_READ, 19'h00000, 16'h0000, 1, 16'hffff, ST_IDLE, 1'b0);
		add_row(OP_READ, 19'h7ffff, 16'hffff, 1, 16'hffff, ST_IDLE, 1'b0);
		add_row(OP_WRITE, 19'h00555, 16'hffaa, 1, 16'h0, ST_UNLOCK, 1'b0);
		add_row(OP_WRITE, 19'h002aa, 16'h0055, 1, 16'h0, ST_COMMAND, 1'b0);
		add_row(OP_WRITE, 19'h00555, 16'h00a0, 1, 16'h0, ST_PROGRAM, 1'b0);
		add_row(OP_WRITE, 19'h00100, 16'h1234, 1, 16'h0, ST_IDLE, 1'b0);
		add_row(OP_READ, 19'h00100, 16'h0000, 0, '0, '0, 1'b0);
		add_row(OP_WRITE, 19'h7f555, 16'h00aa, 1, 16'h0, ST_UNLOCK, 1'b0);
		add_row(OP_WRITE, 19'h002aa, 16'h0055, 1, 16'h0, ST_COMMAND, 1'b0);
		add_row(OP_WRITE, 19'h7f555, 16'h00a0, 1, 16'h0, ST_PROGRAM, 1'b0);
		// A word that would straddle the top of the store is not programmed.
		add_row(OP_WRITE, 19'h7ffff, 16'h0000, 1, 16'h0, ST_IDLE, 1'b0);
		add_row(OP_READ, 19'h7fffe, 16'h0000, 1, 16'hffff, ST_IDLE, 1'b0);
		for (int k = 0; k < 2; k++) begin
			add_row(OP_WRITE, 19'h00555, 16'h00aa, 1, 16'h0, ST_UNLOCK, 1'b0);
			add_row(OP_WRITE, 19'h002aa, 16'h0055, 1, 16'h0, ST_COMMAND, 1'b0);
			add_row(OP_WRITE, 19'h00555, 16'h0080, 1, 16'h0, ST_ERASE_UNLOCK1, 1'b0);
			add_row(OP_WRITE, 19'h00555, 16'h00aa, 1, 16'h0, ST_ERASE_UNLOCK2, 1'b0);
			add_row(OP_WRITE, 19'h002aa, 16'h0055, 1, 16'h0, ST_ERASE_COMMAND, 1'b0);
			// First pass: misaligned sector start; second pass: the 16 KB top sector.
			add_row(OP_WRITE, (k == 0) ? 19'h78001 : 19'h7c000, 16'hff30, 1, 16'h0, ST_IDLE,
				(k == 0) ? 1'b1 : 1'b0);
		end
		add_row(OP_READ, 19'h7c000, 16'h0000, 0, '0, '0, 1'b0);
		run_rows();

		run_phase(GEO_UNIFORM, 20'h00800, 1'b0, 1'b0, 1);
		run_phase(GEO_TOP_2MBIT, 20'h00100, 1'b1, 1'b1, 1);
		run_phase(GEO_TOP_4MBIT, 20'd524288, 1'b0, 1'b1, 0);
		run_phase(2'd3, 20'h02000, 1'b1, 1'b0, 1);
		run_phase(GEO_UNIFORM, 20'h04000, 1'b0, 1'b1, 1);
		run_phase(GEO_TOP_2MBIT, 20'h00000, 1'b1, 1'b1, 1);
		run_phase(GEO_TOP_4MBIT, 20'hfffff, 1'b0, 1'b0, 0);
		run_phase(GEO_UNIFORM, 20'h003ff, 1'b1, 1'b0, 1);
		drain();
		repeat (40) @(posedge clk);
		if (n_errors == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

	// Receiver stall pattern, with one long hold-off so the block backs up.
	initial begin
		int mode, len;
		bit held;
		held = 0;
		out_stall = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (!held && n_checked > 300) begin
				held = 1;
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
			end
			mode = $urandom_range(0, 2);
			len = $urandom_range(20, 200);
			repeat (len) begin
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					default: out_stall <= $urandom_range(0, 1);
				endcase
				@(posedge clk);
			end
		end
	end

	initial n_checked = 0;

	always @(posedge clk) begin
		bus_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			n_checked++;
			if (pending_results.size() == 0) begin
				report("unexpected transaction", command_state, 0);
			end else begin
				want = pending_results.pop_front();
				if (read_data !== want.rd) report("read_data", read_data, want.rd);
				if (command_state !== want.st) report("command_state", command_state, want.st);
				if (erase_error !== want.err) report("erase_error", erase_error, want.err);
			end
		end
	end

endmodule
